// File: rtl/core/pmef_pkg.sv
// Package for the spanning tree edge finder: stream field widths,
// controller state type and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package pmef_pkg;

  // Stream field widths, fixed by the item layout
  localparam int unsigned NODE_W      = 3;
  localparam int unsigned IN_WEIGHT_W = 16;
  localparam int unsigned OUT_W_W     = 16;
  localparam int unsigned IN_TDATA_W  = 32;  // 25 used bits, padded to bytes
  localparam int unsigned OUT_TDATA_W = 24;  // 22 used bits, padded to bytes

  // Request kinds carried in in_tuser
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_START = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic write;  // store one weight
    logic start;  // seed visited map, open round one
    logic step;   // issue one matrix read and advance scan position
    logic emit;   // load result register, close the round
  } cmd_t;

  typedef struct packed {
    logic scan_last;   // scan position is at the final matrix entry
    logic found;       // a candidate edge was seen this round
    logic last_round;  // this round is the final one of a full run
    logic out_free;    // result register can take a new transfer
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/core/pmef_ctrl.sv
// Controller state machine for the spanning tree edge finder.
// Depends on pmef_pkg (state_t, cmd_t, sts_t).
`default_nettype none

module pmef_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  input  wire logic          in_req,
  output logic               in_tready,
  input  var  pmef_pkg::sts_t sts,
  output pmef_pkg::cmd_t     cmd
);
  import pmef_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  assign accept = in_tvalid && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_req == REQ_START)) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          if (!sts.found || sts.last_round) state_nxt = ST_IDLE;
          else                             state_nxt = ST_SCAN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.write = accept && (in_req == REQ_WRITE);
        cmd.start = accept && (in_req == REQ_START);
      end
      ST_SCAN:  cmd.step = 1'b1;
      ST_DRAIN: ;
      ST_EMIT:  cmd.emit = sts.out_free;
      default:  ;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/pmef_dp.sv
// Datapath for the spanning tree edge finder: weight memory with valid bits,
// visited map, scan counters, running minimum and the result register.
// Depends on pmef_pkg (cmd_t, sts_t, widths).
`default_nettype none

module pmef_dp #(
  parameter int unsigned NODES       = 8,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  var  pmef_pkg::cmd_t                    cmd,
  output pmef_pkg::sts_t                         sts,
  input  wire logic [pmef_pkg::NODE_W-1:0]       in_row,
  input  wire logic [pmef_pkg::NODE_W-1:0]       in_col,
  input  wire logic [pmef_pkg::IN_WEIGHT_W-1:0]  in_weight,
  input  wire logic [pmef_pkg::NODE_W-1:0]       in_source,
  input  wire logic                              out_tready,
  output logic                                   out_valid,
  output logic [pmef_pkg::NODE_W-1:0]            out_from,
  output logic [pmef_pkg::NODE_W-1:0]            out_to,
  output logic [pmef_pkg::OUT_W_W-1:0]           out_weight,
  output logic                                   out_found,
  output logic                                   out_last
);
  import pmef_pkg::*;

  localparam int unsigned DEPTH = NODES * NODES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned NB    = $clog2(NODES);
  localparam logic [NB-1:0] MAX_IDX = NB'(NODES - 1);

  // Weight memory and per-entry valid bits (an invalid entry reads as no edge)
  logic [WEIGHT_BITS-1:0] weight_mem_r [DEPTH];
  logic [DEPTH-1:0]       wvld_r;
  logic [WEIGHT_BITS-1:0] rd_w_r;
  logic                   rd_v_r;

  logic [NODES-1:0]       vis_r;
  logic [NB-1:0]          i_r, j_r, ci_r, cj_r, bi_r, bj_r, round_r;
  logic                   cmp_en_r, have_r;
  logic [WEIGHT_BITS-1:0] best_r;

  logic                   out_valid_r, out_found_r, out_last_r;
  logic [NODE_W-1:0]      out_from_r, out_to_r;
  logic [OUT_W_W-1:0]     out_weight_r;

  logic                   wr_ok;
  logic [AW-1:0]          wr_addr, rd_addr;
  logic [WEIGHT_BITS-1:0] w_cur;
  logic                   take;
  logic                   scan_last;

  assign wr_ok   = (32'(in_row) < NODES) && (32'(in_col) < NODES);
  assign wr_addr = AW'(32'(in_row) * NODES + 32'(in_col));
  assign rd_addr = AW'(32'(i_r) * NODES + 32'(j_r));

  always_ff @(posedge clk) begin
    if (cmd.write && wr_ok) weight_mem_r[wr_addr] <= WEIGHT_BITS'(in_weight);
    rd_w_r <= weight_mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvld_r <= '0;
      rd_v_r <= 1'b0;
    end else begin
      if (cmd.write && wr_ok) wvld_r[wr_addr] <= 1'b1;
      rd_v_r <= wvld_r[rd_addr];
    end
  end

  // Candidate test on the registered read
  assign w_cur = rd_v_r ? rd_w_r : '0;
  assign take  = cmp_en_r && vis_r[ci_r] && !vis_r[cj_r] && (w_cur != '0) &&
                 (!have_r || (w_cur < best_r));

  assign scan_last = (i_r == MAX_IDX) && (j_r == MAX_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vis_r    <= '0;
      i_r      <= '0;
      j_r      <= '0;
      round_r  <= '0;
      cmp_en_r <= 1'b0;
      have_r   <= 1'b0;
    end else begin
      cmp_en_r <= cmd.step;
      if (take) have_r <= 1'b1;
      if (cmd.step) begin
        if (j_r == MAX_IDX) begin
          j_r <= '0;
          i_r <= i_r + 1'b1;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
      if (cmd.start) begin
        vis_r   <= (32'(in_source) < NODES) ? (NODES'(1) << in_source) : '0;
        i_r     <= '0;
        j_r     <= '0;
        round_r <= NB'(1);
        have_r  <= 1'b0;
      end
      if (cmd.emit) begin
        if (have_r) vis_r[bj_r] <= 1'b1;
        i_r     <= '0;
        j_r     <= '0;
        round_r <= round_r + 1'b1;
        have_r  <= 1'b0;
      end
    end
  end

  // Payload registers of the scan and the running minimum
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      ci_r <= i_r;
      cj_r <= j_r;
    end
    if (take) begin
      best_r <= w_cur;
      bi_r   <= ci_r;
      bj_r   <= cj_r;
    end
  end

  // Result register: holds while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_found_r  <= have_r;
      out_last_r   <= !have_r || (round_r == MAX_IDX);
      out_from_r   <= have_r ? NODE_W'(bi_r) : '0;
      out_to_r     <= have_r ? NODE_W'(bj_r) : '0;
      out_weight_r <= have_r ? OUT_W_W'(best_r) : '0;
    end
  end

  assign sts.scan_last  = scan_last;
  assign sts.found      = have_r;
  assign sts.last_round = (round_r == MAX_IDX);
  assign sts.out_free   = !out_valid_r || out_tready;

  assign out_valid  = out_valid_r;
  assign out_from   = out_from_r;
  assign out_to     = out_to_r;
  assign out_weight = out_weight_r;
  assign out_found  = out_found_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

// File: rtl/core/prim_mst_edge_finder_unit.sv
// Prim minimum spanning tree edge finder over a stored adjacency matrix.
// Input channel (in_*): one transfer is either a weight write or a start request,
// selected by in_tuser. A write stores one weight (0 = no edge) and produces no
// result. A start clears the visited map, marks the source and runs rounds that
// each emit one tree edge on the result channel (out_*). Each round scans all
// NODES*NODES matrix entries through the weight memory's single read port, one
// entry per cycle, and each registered read is compared against the running
// minimum. A run whose round finds no edge ends early with a found=0 result.
// The final result of a run carries out_tlast.
// in_tready is high only while no run is in progress; the last result may still
// wait in the output register while the next transfer is taken.
// When the receiver stalls, the result register holds its transfer; the next
// round still scans, and its result waits in the emit step until the register
// is free.
// Reset (rst_n low, synchronous) empties the weight store through per-entry
// valid bits, clears the visited map and drops any pending result.
`default_nettype none

module prim_mst_edge_finder_unit #(
  parameter int unsigned NODES       = 8,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [2:0] row, [5:3] col, [21:6] weight, [24:22] source, [31:25] zero
  input  wire logic [pmef_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] req_type: 0 = weight write, 1 = start run
  input  wire logic                              in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [2:0] from_node, [5:3] to_node, [21:6] edge_weight, [23:22] zero
  output logic [pmef_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // [0] found
  output logic                                   out_tuser,
  output logic                                   out_tlast
);
  import pmef_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic [NODE_W-1:0]  out_from, out_to;
  logic [OUT_W_W-1:0] out_weight;

  // Sequence the rounds
  pmef_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_req    (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Store weights, scan the matrix, hold the result
  pmef_dp #(
    .NODES       (NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_row     (in_tdata[2:0]),
    .in_col     (in_tdata[5:3]),
    .in_weight  (in_tdata[21:6]),
    .in_source  (in_tdata[24:22]),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_from   (out_from),
    .out_to     (out_to),
    .out_weight (out_weight),
    .out_found  (out_tuser),
    .out_last   (out_tlast)
  );

  assign out_tdata = {2'b00, out_weight, out_to, out_from};

endmodule

`default_nettype wire

// File: rtl/core/pmef_chk.sv
// Port-level checker for the spanning tree edge finder, bound to the top level.
// Depends on pmef_pkg (widths).
`default_nettype none

module pmef_chk (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [pmef_pkg::IN_TDATA_W-1:0] in_tdata,
  input wire logic                            in_tuser,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [pmef_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                            out_tuser,
  input wire logic                            out_tlast
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // An idle block stays ready until a transfer arrives
  a_idle_stays: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && !in_tvalid |=> in_tready)
    else $error("input ready fell without a transfer");

  // A result without an edge ends the run
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && (out_tdata == '0))
    else $error("no-edge result not final or not zero");

  // A found edge never has zero weight
  a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata[21:6] != 16'd0))
    else $error("found edge with zero weight");

endmodule

bind prim_mst_edge_finder_unit pmef_chk u_pmef_chk (.*);

`default_nettype wire

// File: sim/prim_mst_edge_finder_unit_test.sv
// Self-checking testbench for prim_mst_edge_finder_unit: weight writes and spanning
// tree runs on the stream ports, checked against a predictor of the tree edges.
// Depends on pmef_pkg and the unit itself.

module prim_mst_edge_finder_unit_test;
  import pmef_pkg::*;

  localparam int NODE_COUNT  = 8;
  localparam int WGT_BITS    = 16;
  localparam int CLK_HALF    = 4;
  localparam int RESET_TICKS = 11;
  localparam int RAND_ITEMS  = 150;
  localparam int DRAIN_TICKS = 600;   // one full run plus margin
  localparam int MAX_REPORTS = 10;

  // Who idles in the current phase of the stimulus
  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic [NODE_W-1:0]  from_node;
    logic [NODE_W-1:0]  to_node;
    logic [OUT_W_W-1:0] edge_weight;
    logic               found;
    logic               last;
  } tree_edge_t;

  // Holds its own copy of the weight matrix and the tree edges still owed
  class mst_scoreboard;
    logic [IN_WEIGHT_W-1:0] weights [NODE_COUNT][NODE_COUNT];
    tree_edge_t             owed_edges[$];
    int                     mismatches;

    function new();
      foreach (weights[i, j]) weights[i][j] = '0;
      mismatches = 0;
    endfunction

    function void note_mismatch(string what, tree_edge_t want, tree_edge_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t %s: expected from=%0d to=%0d w=%0d found=%0b last=%0b",
                 $realtime, what, want.from_node, want.to_node, want.edge_weight,
                 want.found, want.last);
        $display("%0t %s: actual   from=%0d to=%0d w=%0d found=%0b last=%0b",
                 $realtime, what, got.from_node, got.to_node, got.edge_weight,
                 got.found, got.last);
      end
    endfunction

    // Prim rounds: cheapest nonzero edge from a visited row into an unvisited
    // column, first in row-major order on a tie
    function void grow_tree(logic [NODE_W-1:0] source);
      logic [NODE_COUNT-1:0]  visited;
      logic [IN_WEIGHT_W-1:0] best;
      bit                     have;
      int                     bi;
      int                     bj;
      tree_edge_t             e;
      visited = '0;
      visited[source] = 1'b1;
      for (int rnd = 1; rnd < NODE_COUNT; rnd++) begin
        have = 1'b0;
        best = '0;
        bi = 0;
        bj = 0;
        for (int i = 0; i < NODE_COUNT; i++) begin
          for (int j = 0; j < NODE_COUNT; j++) begin
            if (visited[i] && !visited[j] && weights[i][j] != 0 &&
                (!have || weights[i][j] < best)) begin
              have = 1'b1;
              best = weights[i][j];
              bi = i;
              bj = j;
            end
          end
        end
        if (!have) begin
          e = '{from_node: '0, to_node: '0, edge_weight: '0, found: 1'b0, last: 1'b1};
          owed_edges.push_back(e);
          return;
        end
        visited[bj] = 1'b1;
        e = '{from_node: NODE_W'(bi), to_node: NODE_W'(bj), edge_weight: best,
              found: 1'b1, last: (rnd == NODE_COUNT - 1)};
        owed_edges.push_back(e);
      end
    endfunction

    function void note_transfer(logic req, logic [IN_TDATA_W-1:0] data);
      if (req == REQ_WRITE)
        weights[data[2:0]][data[5:3]] = data[21:6];
      else
        grow_tree(data[24:22]);
    endfunction

    function void check_edge(tree_edge_t got);
      tree_edge_t want;
      if (owed_edges.size() == 0) begin
        note_mismatch("result with nothing owed", got, got);
        return;
      end
      want = owed_edges.pop_front();
      if (got.from_node !== want.from_node || got.to_node !== want.to_node ||
          got.edge_weight !== want.edge_weight || got.found !== want.found ||
          got.last !== want.last)
        note_mismatch("edge mismatch", want, got);
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata   = '0;
  logic                  in_tuser   = REQ_WRITE;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  idle_mode_t    idle_mode = IDLE_NONE;
  mst_scoreboard sb        = new();

  prim_mst_edge_finder_unit #(
    .NODES       (NODE_COUNT),
    .WEIGHT_BITS (WGT_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Roll the dice for idling on either side of the block
  function automatic bit roll_idle(bit sender_side);
    int pct;
    pct = $urandom_range(0, 99);
    case (idle_mode)
      IDLE_SEND: return sender_side && pct < 51;
      IDLE_RECV: return !sender_side && pct < 51;
      IDLE_BOTH: return pct < 12;
      default:   return 1'b0;
    endcase
  endfunction

  // Mix of zero (edge removal), narrow weights that force ties, and full range
  function automatic logic [IN_WEIGHT_W-1:0] pick_weight();
    int pct;
    pct = $urandom_range(0, 99);
    if (pct < 15)
      return '0;
    else if (pct < 55)
      return IN_WEIGHT_W'($urandom_range(1, 8));
    else
      return IN_WEIGHT_W'($urandom_range(1, 65535));
  endfunction

  // Offer one transfer; hold tvalid and data until the block takes it. tvalid
  // stays high between back-to-back transfers so it never toggles within a step.
  task automatic send_item(input logic req, input logic [NODE_W-1:0] row, col,
                           input logic [IN_WEIGHT_W-1:0] weight,
                           input logic [NODE_W-1:0] source);
    while (roll_idle(1'b1)) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {7'b0, source, weight, col, row};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_transfer(in_tuser, in_tdata);
  endtask

  // Fields unused by the request carry random values; the top pad bits stay zero
  task automatic write_weight(input int row, input int col, input int weight);
    send_item(REQ_WRITE, NODE_W'(row), NODE_W'(col), IN_WEIGHT_W'(weight),
              NODE_W'($urandom_range(0, 7)));
  endtask

  task automatic start_run(input int source);
    send_item(REQ_START, NODE_W'($urandom_range(0, 7)), NODE_W'($urandom_range(0, 7)),
              IN_WEIGHT_W'($urandom), NODE_W'(source));
  endtask

  // Result side: check each transfer, then decide whether to stall next cycle
  always @(posedge clk) begin
    tree_edge_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.from_node   = out_tdata[2:0];
      got.to_node     = out_tdata[5:3];
      got.edge_weight = out_tdata[21:6];
      got.found       = out_tuser;
      got.last        = out_tlast;
      sb.check_edge(got);
    end
    out_tready <= rst_n && !roll_idle(1'b0);
  end

  initial begin
    repeat (RESET_TICKS) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, no idling: empty store ends runs on round one
    start_run(0);
    start_run(7);
    // Self loop never qualifies; max weight is the only way out of vertex 0
    write_weight(0, 0, 5);
    write_weight(7, 7, 65535);
    write_weight(0, 1, 65535);
    start_run(0);
    // Weight 3 into vertex 2 from both row 0 and row 1
    write_weight(1, 2, 3);
    write_weight(0, 2, 3);
    // Chain the rest so a run from 0 covers every vertex
    write_weight(2, 3, 1);
    write_weight(3, 4, 2);
    write_weight(4, 5, 65534);
    write_weight(5, 6, 7);
    write_weight(6, 7, 32768);
    start_run(0);
    start_run(7);
    start_run(3);
    // Erase an edge with a zero weight, then rerun
    write_weight(0, 1, 0);
    start_run(0);
    start_run(1);

    // Random part: mostly writes that grow the graph, starts in between;
    // walk through the four idling phases
    for (int n = 0; n < RAND_ITEMS; n++) begin
      idle_mode = idle_mode_t'((n * 4) / RAND_ITEMS);
      if ($urandom_range(0, 99) < 20)
        start_run($urandom_range(0, 7));
      else
        write_weight($urandom_range(0, 7), $urandom_range(0, 7), pick_weight());
    end

    // Drop tvalid, let owed edges drain, then watch for strays
    @(posedge clk);
    in_tvalid <= 1'b0;
    while (sb.owed_edges.size() != 0) @(posedge clk);
    repeat (DRAIN_TICKS) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #(2 * CLK_HALF * 500000);
    $display("simulation failed");
    $finish;
  end

endmodule
